// ===== src/fpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the framed packet receiver
// Frame geometry, register indexes, status codes and the result record.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int MAX_FRAME_BYTES = 1024;
  localparam int HEADER_BYTES    = 8;
  localparam int LEN_CHECK_COUNT = 6;

  // byte counter must hold MAX_FRAME_BYTES itself for the limit compare
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  // 16-bit length plus header still has to fit for the end-of-frame compare
  localparam int LEN_W = 17;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(1);

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    STATUS_IDLE   = 2'd0,
    STATUS_ACCEPT = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic [1:0] frame_status;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } result_t;

endpackage

// ===== src/fpr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_in_if: received byte channel
// Valid/ready channel carrying one received byte per request.
// ----------------------------------------------------------------------------
interface fpr_in_if import fpr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/fpr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_out_if: parse result channel
// Valid/ready channel carrying frame status and passed-through payload bytes.
// ----------------------------------------------------------------------------
interface fpr_out_if import fpr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic       payload_valid;
  logic [7:0] payload_byte;

  modport source (output valid, output frame_status, output payload_valid,
                  output payload_byte, input ready);
  modport sink   (input valid, input frame_status, input payload_valid,
                  input payload_byte, output ready);
endinterface

// ===== src/framed_packet_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver: sync byte frame parser with ones-complement checksum
// Parses byte-serial frames and streams payload bytes with a frame status.
// ----------------------------------------------------------------------------
// path: an accepted byte goes through the input register, then the result register
// throughput: one byte per cycle while the output is not stalled, set by the parser
// state update between the input register and the result register
// reset: synchronous; pipeline empties, parser returns to sync search,
// sync bytes go to 0xAA and 0x55
module framed_packet_receiver import fpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fpr_in_if.sink               in_ch,
  fpr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t       cfg;
  result_t    result;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;

  logic       advance;
  logic       in_ready;
  logic       step;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;
  assign step     = s1_valid_r && advance;

  fpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= result;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_status  = out_res_r.frame_status;
  assign out_ch.payload_valid = out_res_r.payload_valid;
  assign out_ch.payload_byte  = out_res_r.payload_byte;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.frame_status != 2'd3)
    else $error("undefined frame status");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.payload_valid |-> out_res_r.payload_byte == 8'h00)
    else $error("payload byte set on non-payload result");

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r && out_res_r == $past(result))
    else $error("result register missed a parser step");

endmodule

// ===== src/fpr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_cfg_regs: sync byte configuration registers
// Write-only register file holding the two sync bytes.
// ----------------------------------------------------------------------------
module fpr_cfg_regs import fpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data[7:0];
        REG_SYNC_SECOND: cfg_r.sync_second <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/fpr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_parser: header parser and checksum accumulator
// Holds the frame state and works out the result of one byte per step.
// ----------------------------------------------------------------------------
module fpr_parser import fpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  cnt_t        cnt_r, cnt_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [7:0]  exp_hi_r, exp_hi_nxt;
  logic [7:0]  exp_lo_r, exp_lo_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  pend_r, pend_nxt;

  cnt_t        cnt_inc;
  logic        is_payload;
  logic        odd_byte;
  logic [15:0] word;
  logic [16:0] sum_raw;
  logic [15:0] sum_all;
  logic [15:0] exp_cur;
  logic [LEN_W-1:0] frame_end;
  result_t     res;

  assign cnt_inc    = cnt_r + cnt_t'(1);
  assign is_payload = (cnt_r >= cnt_t'(HEADER_BYTES));
  assign odd_byte   = cnt_r[0];

  // ones-complement add with end-around carry, same as folding the wide sum
  assign word    = !is_payload ? 16'h0000 : (odd_byte ? {pend_r, rx_byte} : {8'h00, rx_byte});
  assign sum_raw = {1'b0, acc_r} + {1'b0, word};
  assign sum_all = sum_raw[15:0] + {15'h0000, sum_raw[16]};

  // expected low byte arrives on the last header byte of an empty frame
  assign exp_cur   = {exp_hi_r, (cnt_r == cnt_t'(HEADER_BYTES - 1)) ? rx_byte : exp_lo_r};
  assign frame_end = {1'b0, len_hi_r, len_lo_r} + LEN_W'(HEADER_BYTES);

  always_comb begin
    cnt_nxt    = cnt_r;
    len_hi_nxt = len_hi_r;
    len_lo_nxt = len_lo_r;
    exp_hi_nxt = exp_hi_r;
    exp_lo_nxt = exp_lo_r;
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    res.frame_status  = STATUS_IDLE;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'h00;

    if (cnt_r == cnt_t'(0)) begin
      if (rx_byte == cfg.sync_first) begin
        cnt_nxt  = cnt_t'(1);
        acc_nxt  = 16'h0000;
        pend_nxt = 8'h00;
      end
    end else if (cnt_r == cnt_t'(1) && rx_byte != cfg.sync_second) begin
      cnt_nxt = cnt_t'(0);
    end else begin
      cnt_nxt = cnt_inc;
      if (cnt_r == cnt_t'(2)) begin
        len_hi_nxt = rx_byte;
      end else if (cnt_r == cnt_t'(3)) begin
        len_lo_nxt = rx_byte;
      end else if (cnt_r == cnt_t'(LEN_CHECK_COUNT)) begin
        exp_hi_nxt = rx_byte;
      end else if (cnt_r == cnt_t'(HEADER_BYTES - 1)) begin
        exp_lo_nxt = rx_byte;
      end else if (is_payload) begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        if (odd_byte) begin
          acc_nxt = sum_all;
        end else begin
          pend_nxt = rx_byte;
        end
      end

      if (cnt_inc == cnt_t'(LEN_CHECK_COUNT)) begin
        if ((len_hi_r ^ len_lo_r) != rx_byte) begin
          cnt_nxt = cnt_t'(0);
        end
      end else if (cnt_inc >= cnt_t'(MAX_FRAME_BYTES)) begin
        res.frame_status = STATUS_REJECT;
        cnt_nxt          = cnt_t'(0);
      end else if (cnt_inc > cnt_t'(LEN_CHECK_COUNT)) begin
        if (frame_end == LEN_W'(cnt_inc)) begin
          res.frame_status = (~sum_all == exp_cur) ? STATUS_ACCEPT : STATUS_REJECT;
          cnt_nxt          = cnt_t'(0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= cnt_t'(0);
      len_hi_r <= 8'h00;
      len_lo_r <= 8'h00;
      exp_hi_r <= 8'h00;
      exp_lo_r <= 8'h00;
      acc_r    <= 16'h0000;
      pend_r   <= 8'h00;
    end else if (step) begin
      cnt_r    <= cnt_nxt;
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
      exp_hi_r <= exp_hi_nxt;
      exp_lo_r <= exp_lo_nxt;
      acc_r    <= acc_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign result = res;

endmodule

// ===== dv/framed_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_tb: self-checking bench for the framed packet receiver
// Streams good, corrupted and truncated frames plus line noise under several
// sync byte settings, with random gaps on both channels and one long output
// stall. Every result is compared with a cycle-free parser model.
// ----------------------------------------------------------------------------
module framed_packet_receiver_tb;
  import fpr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 5;
  localparam int MAX_PAYLOAD  = MAX_FRAME_BYTES - HEADER_BYTES;

  // no register behind this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_SYNC,
    FR_BAD_CHECK,
    FR_CUT
  } frame_kind_t;

  class frame_scoreboard;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    cnt_t        count;
    logic [7:0]  len_hi, len_lo;
    logic [7:0]  sum_hi, sum_lo;
    logic [7:0]  pend_hi;
    logic [31:0] word_sum;
    result_t     want_q[$];
    int          errors;

    function new();
      sync_first  = SYNC_FIRST_RST;
      sync_second = SYNC_SECOND_RST;
      count       = '0;
      len_hi      = '0;
      len_lo      = '0;
      sum_hi      = '0;
      sum_lo      = '0;
      pend_hi     = '0;
      word_sum    = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_SYNC_FIRST:  sync_first  = data;
        REG_SYNC_SECOND: sync_second = data;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t     r;
      cnt_t        pos;
      logic [15:0] len;
      logic [31:0] s;
      logic [15:0] want_sum;
      r = '0;
      r.frame_status = STATUS_IDLE;
      if (count == 0) begin
        if (b == sync_first) begin
          count    = cnt_t'(1);
          word_sum = '0;
          pend_hi  = '0;
        end
      end else if (count == 1 && b != sync_second) begin
        count = '0;
      end else begin
        pos   = count;
        count = pos + 1'b1;
        case (pos)
          2: len_hi = b;
          3: len_lo = b;
          6: sum_hi = b;
          7: sum_lo = b;
          default: begin
            if (pos >= HEADER_BYTES) begin
              r.payload_valid = 1'b1;
              r.payload_byte  = b;
              // header length is even, so odd positions close a pair
              if (pos[0]) word_sum = word_sum + {16'b0, pend_hi, b};
              else pend_hi = b;
            end
          end
        endcase
        if (count == LEN_CHECK_COUNT) begin
          if ((len_hi ^ len_lo) != b) count = '0;
        end else if (count >= MAX_FRAME_BYTES) begin
          r.frame_status = STATUS_REJECT;
          count = '0;
        end else if (count > LEN_CHECK_COUNT) begin
          len = {len_hi, len_lo};
          if (int'(len) + HEADER_BYTES == int'(count)) begin
            s = word_sum;
            if (len[0]) s = s + {24'b0, pend_hi};
            s = {16'b0, s[31:16]} + {16'b0, s[15:0]};
            s = {16'b0, s[31:16]} + {16'b0, s[15:0]};
            want_sum = ~s[15:0];
            r.frame_status = (want_sum == {sum_hi, sum_lo}) ? STATUS_ACCEPT : STATUS_REJECT;
            count = '0;
          end
        end
      end
      want_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (want_q.size() == 0) begin
        $error("result with no request waiting: status %0d valid %0d byte 0x%02h",
               got.frame_status, got.payload_valid, got.payload_byte);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, actual %0d", want.frame_status, got.frame_status);
        errors++;
      end
      if (got.payload_valid !== want.payload_valid) begin
        $error("payload_valid: expected %0d, actual %0d",
               want.payload_valid, got.payload_valid);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected 0x%02h, actual 0x%02h",
               want.payload_byte, got.payload_byte);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  fpr_in_if  in_ch ();
  fpr_out_if out_ch ();

  framed_packet_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_scoreboard sb = new();

  bit quiet;        // no gaps on either side while set
  bit force_quiet;
  bit hold_req;
  int counted_bytes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** framed_packet_receiver: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
  endtask

  // builds one frame on the current sync bytes, possibly damaged, and sends it
  task automatic send_frame(input int len, input frame_kind_t kind);
    logic [7:0]  pay[$];
    logic [7:0]  bytes[$];
    logic [31:0] acc;
    logic [15:0] sum;
    logic [7:0]  chk;
    int          n_pay;
    int          n_send;
    n_pay = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
    acc = '0;
    for (int i = 0; i < n_pay; i++) begin
      pay.push_back(8'($urandom_range(0, 255)));
      if (i[0]) acc = acc + {16'b0, pay[i-1], pay[i]};
    end
    if (n_pay[0]) acc = acc + {24'b0, pay[n_pay-1]};
    acc = {16'b0, acc[31:16]} + {16'b0, acc[15:0]};
    acc = {16'b0, acc[31:16]} + {16'b0, acc[15:0]};
    sum = ~acc[15:0];
    if (kind == FR_BAD_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
    chk = len[15:8] ^ len[7:0];
    if (kind == FR_BAD_CHECK) chk = chk ^ 8'($urandom_range(1, 255));

    bytes.push_back(sb.sync_first);
    if (kind == FR_BAD_SYNC) begin
      bytes.push_back(sb.sync_second ^ 8'($urandom_range(1, 255)));
    end else begin
      bytes.push_back(sb.sync_second);
      bytes.push_back(len[15:8]);
      bytes.push_back(len[7:0]);
      bytes.push_back(8'($urandom_range(0, 255)));
      bytes.push_back(chk);
      if (kind != FR_BAD_CHECK) begin
        bytes.push_back(sum[15:8]);
        bytes.push_back(sum[7:0]);
        foreach (pay[i]) bytes.push_back(pay[i]);
      end
    end
    n_send = (kind == FR_CUT) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    for (int i = 0; i < n_send; i++) send_byte(bytes[i]);
    if (len <= 64) counted_bytes += n_send;
  endtask

  task automatic program_sync(input logic [7:0] first, input logic [7:0] second);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    sb.write_reg(REG_SYNC_FIRST, first);
    cfg_index <= REG_SYNC_SECOND;
    cfg_data  <= second;
    @(posedge clk);
    sb.write_reg(REG_SYNC_SECOND, second);
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    sb.write_reg(REG_SPARE, junk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_frame();
    int          len;
    int          pick;
    frame_kind_t kind;
    quiet = force_quiet || ($urandom_range(0, 3) == 0);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    pick = $urandom_range(0, 99);
    if (pick < 60) kind = FR_GOOD;
    else if (pick < 75) kind = FR_BAD_SUM;
    else if (pick < 83) kind = FR_BAD_SYNC;
    else if (pick < 91) kind = FR_BAD_CHECK;
    else kind = FR_CUT;
    // line noise between frames, which may itself look like a sync byte
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
    send_frame(len, kind);
  endtask

  // result side: random stall per result, one long hold-off on request
  initial begin
    int      gap;
    result_t got;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.frame_status  = out_ch.frame_status;
      got.payload_valid = out_ch.payload_valid;
      got.payload_byte  = out_ch.payload_byte;
      sb.check_result(got);
    end
  end

  initial begin
    logic [7:0] rnd;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SYNC_FIRST;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    quiet         = 1'b0;
    force_quiet   = 1'b0;
    hold_req      = 1'b0;
    counted_bytes = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: noise extremes, empty frame, bad sync, bad length check, odd payload
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, FR_GOOD);
    send_frame(0, FR_BAD_SYNC);
    send_frame(0, FR_BAD_CHECK);
    send_frame(1, FR_GOOD);
    drain();

    counted_bytes = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      rnd = 8'($urandom_range(0, 255));
      case (ph)
        0: program_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
        1: program_sync(8'h00, 8'hFF);
        2: program_sync(8'hFF, 8'h00);
        3: program_sync(rnd, 8'($urandom_range(0, 255)));
        default: program_sync(rnd, rnd);
      endcase
      force_quiet = (ph == 2);
      if (ph == 2) hold_req = 1'b1;
      // frame that runs into the size limit on the byte that would end it
      if (ph == 1) send_frame(MAX_PAYLOAD, FR_GOOD);
      while (counted_bytes < (ph + 1) * PHASE_ITEMS) random_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("** framed_packet_receiver: PASSED **");
    end else begin
      $display("** framed_packet_receiver: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fpr_pkg.sv
src/fpr_in_if.sv
src/fpr_out_if.sv
src/fpr_cfg_regs.sv
src/fpr_parser.sv
src/framed_packet_receiver.sv
dv/framed_packet_receiver_tb.sv
